[hdl/assert_macros.svh]
// Assertion macros shared by the kicker controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kcf assertion failed");

// Next-cycle implication, checked outside reset
`define KCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kcf assertion failed");

`endif

[hdl/kcf_pkg.sv]
// Shared types, codes, reset values and helpers for the kicker controller
package kcf_pkg;

	// Event codes
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_KICK   = 3'd1;
	localparam logic [2:0] MODE_ARM    = 3'd2;
	localparam logic [2:0] MODE_CANCEL = 3'd3;
	localparam logic [2:0] MODE_SETCHG = 3'd4;
	localparam logic [2:0] MODE_TOGCHG = 3'd5;

	// Register indexes
	localparam logic [2:0] REG_PRE      = 3'd0;
	localparam logic [2:0] REG_PULSE    = 3'd1;
	localparam logic [2:0] REG_POST     = 3'd2;
	localparam logic [2:0] REG_HOLDOFF  = 3'd3;
	localparam logic [2:0] REG_VHIGH    = 3'd4;
	localparam logic [2:0] REG_VLOW     = 3'd5;
	localparam logic [2:0] REG_DEBOUNCE = 3'd6;
	localparam logic [2:0] REG_WEIGHT   = 3'd7;

	// Register reset values
	localparam logic [7:0]  RST_PRE      = 8'd50;
	localparam logic [7:0]  RST_PULSE    = 8'd10;
	localparam logic [7:0]  RST_POST     = 8'd50;
	localparam logic [15:0] RST_HOLDOFF  = 16'd20000;
	localparam logic [7:0]  RST_VHIGH    = 8'd239;
	localparam logic [7:0]  RST_VLOW     = 8'd232;
	localparam logic [3:0]  RST_DEBOUNCE = 4'd5;
	localparam logic [7:0]  RST_WEIGHT   = 8'd32;

	localparam logic [7:0]  WEIGHT_FULL  = 8'd255;

	typedef struct packed {
		logic [7:0]  pre_ticks;
		logic [7:0]  pulse_ticks;
		logic [7:0]  post_ticks;
		logic [15:0] holdoff_ticks;
		logic [7:0]  volt_high;
		logic [7:0]  volt_low;
		logic [3:0]  debounce_limit;
		logic [7:0]  filter_weight;
	} kcf_cfg_t;

	// Decoded event
	typedef struct packed {
		logic tick;
		logic kick;
		logic arm;
		logic cancel;
		logic set_chg;
		logic tog_chg;
	} kcf_op_t;

	// Kick sequencer view
	typedef struct packed {
		logic permit;
		logic kick;
		logic busy;
	} kcf_seq_t;

	// Filter, charger and debounce view
	typedef struct packed {
		logic [7:0] avg;
		logic       ball;
		logic       chg;
	} kcf_sense_t;

	// floor(acc / 255) for acc below 65280, by shift and add
	function automatic logic [7:0] div255(input logic [15:0] acc);
		logic [16:0] t;
		t = {1'b0, acc} + {9'd0, acc[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

[hdl/kicker_charge_and_fire_controller.sv]
// Kicker charge and fire controller top level
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------------
//   in       | in_valid / in_stall     | mode strength charge_on ball_sample volt...
//   out      | out_valid / out_stall   | kick_drive charge_drive ball_present ... volt
//   cfg      | cfg_valid / cfg_ready   | cfg_index cfg_data
//
// Each item passes through the input register, then through the filter, sequencer and
// debounce logic into the result register.
// An item is accepted every cycle while the output is not stalled; the state loop through
// the sequencer and the filter multiply-add closes combinationally.
// Reset clears the control state and loads the register defaults, but not the data
// registers; the charger starts permitted. A stall on the output holds the result
// and backs up into in_stall once the input register is also full.
`include "assert_macros.svh"

module kicker_charge_and_fire_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [7:0]  strength,
	input  logic        charge_on,
	input  logic        ball_sample,
	input  logic [7:0]  voltage_sample,
	input  logic        sample_valid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kick_drive,
	output logic        charge_drive,
	output logic        ball_present,
	output logic        charge_requested,
	output logic        armed,
	output logic        kicking,
	output logic [7:0]  filtered_voltage,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kcf_pkg::*;

	kcf_cfg_t   cfg_q;
	logic       v_s1;
	logic [2:0] mode_s1;
	logic [7:0] strength_s1, volt_s1;
	logic       chg_on_s1, ball_s1, svalid_s1;
	logic [7:0] arm_strength_q;
	logic       arm_q, req_q;
	logic       adv, fire, arm_n, req_n;
	kcf_op_t    op;
	kcf_seq_t   seq_cur, seq_nxt;
	kcf_sense_t sense_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_ticks      <= RST_PRE;
			cfg_q.pulse_ticks    <= RST_PULSE;
			cfg_q.post_ticks     <= RST_POST;
			cfg_q.holdoff_ticks  <= RST_HOLDOFF;
			cfg_q.volt_high      <= RST_VHIGH;
			cfg_q.volt_low       <= RST_VLOW;
			cfg_q.debounce_limit <= RST_DEBOUNCE;
			cfg_q.filter_weight  <= RST_WEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PRE:      cfg_q.pre_ticks      <= cfg_data[7:0];
				REG_PULSE:    cfg_q.pulse_ticks    <= cfg_data[7:0];
				REG_POST:     cfg_q.post_ticks     <= cfg_data[7:0];
				REG_HOLDOFF:  cfg_q.holdoff_ticks  <= cfg_data;
				REG_VHIGH:    cfg_q.volt_high      <= cfg_data[7:0];
				REG_VLOW:     cfg_q.volt_low       <= cfg_data[7:0];
				REG_DEBOUNCE: cfg_q.debounce_limit <= cfg_data[3:0];
				REG_WEIGHT:   cfg_q.filter_weight  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// move the held item on when the result register is free or being taken
	assign adv      = v_s1 && (!out_valid || !out_stall);
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= (in_valid && !in_stall) || (v_s1 && !adv);
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1     <= mode;
			strength_s1 <= strength;
			chg_on_s1   <= charge_on;
			ball_s1     <= ball_sample;
			volt_s1     <= voltage_sample;
			svalid_s1   <= sample_valid;
		end
	end

	always_comb begin
		op = '0;
		case (mode_s1)
			MODE_TICK:   op.tick    = 1'b1;
			MODE_KICK:   op.kick    = 1'b1;
			MODE_ARM:    op.arm     = 1'b1;
			MODE_CANCEL: op.cancel  = 1'b1;
			MODE_SETCHG: op.set_chg = 1'b1;
			MODE_TOGCHG: op.tog_chg = 1'b1;
			default: ;
		endcase
	end

	kcf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.op     (op),
		.fire   (fire),
		.cur    (seq_cur),
		.nxt    (seq_nxt)
	);

	kcf_sense u_sense (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.cfg     (cfg_q),
		.tick    (op.tick),
		.ball    (ball_s1),
		.volt    (volt_s1),
		.valid   (svalid_s1),
		.permit  (seq_nxt.permit),
		.request (req_q),
		.nxt     (sense_nxt)
	);

	// an armed kick fires once the debounced ball is seen on a tick
	assign fire = op.tick && sense_nxt.ball && arm_q;

	always_comb begin
		arm_n = arm_q;
		req_n = req_q;
		if (op.arm)
			arm_n = 1'b1;
		if (op.cancel || fire)
			arm_n = 1'b0;
		if (op.set_chg)
			req_n = chg_on_s1;
		if (op.tog_chg)
			req_n = ~req_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q          <= 1'b0;
			req_q          <= 1'b0;
			arm_strength_q <= 8'd0;
		end else if (adv) begin
			arm_q <= arm_n;
			req_q <= req_n;
			if (op.arm)
				arm_strength_q <= strength_s1;
			else if (op.cancel)
				arm_strength_q <= 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kick_drive       <= seq_nxt.kick;
			charge_drive     <= sense_nxt.chg;
			ball_present     <= sense_nxt.ball;
			charge_requested <= req_n;
			armed            <= arm_n;
			kicking          <= seq_nxt.busy;
			filtered_voltage <= sense_nxt.avg;
		end
	end

	`KCF_ASSERT_NXT(a_adv_result, clk, arst_n, adv, out_valid)
	`KCF_ASSERT_NXT(a_held_item, clk, arst_n, v_s1 && !adv, v_s1)
	`KCF_ASSERT_NXT(a_fire_disarm, clk, arst_n, adv && fire, !arm_q)
	`KCF_ASSERT_NXT(a_cancel_clears, clk, arst_n, adv && op.cancel,
		!arm_q && arm_strength_q == 8'd0)
	`KCF_ASSERT_IMP(a_kick_busy, clk, arst_n,
		adv && op.kick && !seq_cur.busy && cfg_q.pulse_ticks != 8'd0, seq_nxt.busy)

endmodule

[hdl/kcf_seq.sv]
// Kick sequencer: pre, pulse, post and holdoff phase counters
module kcf_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  kcf_pkg::kcf_cfg_t cfg,
	input  kcf_pkg::kcf_op_t  op,
	input  logic             fire,
	output kcf_pkg::kcf_seq_t cur,
	output kcf_pkg::kcf_seq_t nxt
);
	import kcf_pkg::*;

	logic [7:0]  pre_q, pulse_q, post_q;
	logic [15:0] hold_q;
	logic        kick_q, permit_q;

	logic [7:0]  pre_n, pulse_n, post_n;
	logic [15:0] hold_n;
	logic        kick_n, permit_n;
	logic        busy_step, start;

	always_comb begin
		pre_n    = pre_q;
		pulse_n  = pulse_q;
		post_n   = post_q;
		hold_n   = hold_q;
		kick_n   = kick_q;
		permit_n = permit_q;
		// on a tick, count down the current phase
		if (op.tick) begin
			if (pre_q != 8'd0) begin
				permit_n = 1'b0;
				pre_n    = pre_q - 8'd1;
			end else if (pulse_q != 8'd0) begin
				kick_n  = 1'b1;
				pulse_n = pulse_q - 8'd1;
			end else if (post_q != 8'd0) begin
				kick_n = 1'b0;
				post_n = post_q - 8'd1;
			end else begin
				kick_n   = 1'b0;
				permit_n = 1'b1;
				if (hold_q != 16'd0)
					hold_n = hold_q - 16'd1;
			end
		end
		busy_step = (pre_n != 8'd0) || (pulse_n != 8'd0) || (post_n != 8'd0) ||
			(hold_n != 16'd0);
		start = op.kick ? !cur.busy : (fire && !busy_step);
		if (start) begin
			pre_n   = cfg.pre_ticks;
			pulse_n = cfg.pulse_ticks;
			post_n  = cfg.post_ticks;
			hold_n  = cfg.holdoff_ticks;
		end
		nxt.permit = permit_n;
		nxt.kick   = kick_n;
		nxt.busy   = (pre_n != 8'd0) || (pulse_n != 8'd0) || (post_n != 8'd0) ||
			(hold_n != 16'd0);
	end

	assign cur.permit = permit_q;
	assign cur.kick   = kick_q;
	assign cur.busy   = (pre_q != 8'd0) || (pulse_q != 8'd0) || (post_q != 8'd0) ||
		(hold_q != 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q    <= 8'd0;
			pulse_q  <= 8'd0;
			post_q   <= 8'd0;
			hold_q   <= 16'd0;
			kick_q   <= 1'b0;
			permit_q <= 1'b1;
		end else if (adv) begin
			pre_q    <= pre_n;
			pulse_q  <= pulse_n;
			post_q   <= post_n;
			hold_q   <= hold_n;
			kick_q   <= kick_n;
			permit_q <= permit_n;
		end
	end

endmodule

[hdl/kcf_sense.sv]
// Voltage filter, charger hysteresis and ball-sense debounce
module kcf_sense (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  kcf_pkg::kcf_cfg_t   cfg,
	input  logic               tick,
	input  logic               ball,
	input  logic [7:0]         volt,
	input  logic               valid,
	input  logic               permit,
	input  logic               request,
	output kcf_pkg::kcf_sense_t nxt
);
	import kcf_pkg::*;

	logic [7:0]  avg_q;
	logic        ball_q, chg_q;
	logic [4:0]  mis_q;

	logic [15:0] prod_old, prod_new;
	logic [15:0] acc;
	logic [7:0]  avg_n;
	logic        chg_base, chg_n, ball_n;
	logic [4:0]  mis_inc, mis_n;

	always_comb begin
		prod_old = 16'((WEIGHT_FULL - cfg.filter_weight) * avg_q);
		prod_new = 16'(cfg.filter_weight * volt);
		// the two weights sum to 255, so the sum stays below 65280
		acc      = prod_old + prod_new;
		avg_n    = valid ? div255(acc) : avg_q;

		// the pre, pulse and post phases force the charger off before the hysteresis
		chg_base = permit ? chg_q : 1'b0;
		if ((avg_n > cfg.volt_high) || !permit || !request)
			chg_n = 1'b0;
		else if (avg_n < cfg.volt_low)
			chg_n = 1'b1;
		else
			chg_n = chg_base;

		mis_inc = (ball != ball_q) ? (mis_q + 5'd1) : 5'd0;
		ball_n  = ball_q;
		mis_n   = mis_inc;
		if (mis_inc > {1'b0, cfg.debounce_limit}) begin
			mis_n  = 5'd0;
			ball_n = ~ball_q;
		end

		nxt.avg  = tick ? avg_n : avg_q;
		nxt.ball = tick ? ball_n : ball_q;
		nxt.chg  = tick ? chg_n : chg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q  <= 8'd0;
			ball_q <= 1'b0;
			chg_q  <= 1'b0;
			mis_q  <= 5'd0;
		end else if (adv && tick) begin
			avg_q  <= avg_n;
			ball_q <= ball_n;
			chg_q  <= chg_n;
			mis_q  <= mis_n;
		end
	end

endmodule
